/* design/nrfe_pkg.sv */
`default_nettype none

package nrfe_pkg;

  // Default capacity of the time, latitude and longitude buffers
  localparam int unsigned FIELD_CHARS_DEF = 12;

  // Characters the parser acts on
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_M       = 8'h4D;
  localparam logic [7:0] CHAR_C       = 8'h43;
  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_V       = 8'h56;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;

  // Field identifiers as they appear on the result stream
  localparam logic [2:0] FID_TIME = 3'd0;
  localparam logic [2:0] FID_LAT  = 3'd1;
  localparam logic [2:0] FID_NS   = 3'd2;
  localparam logic [2:0] FID_LON  = 3'd3;
  localparam logic [2:0] FID_EW   = 3'd4;

  // Result record kinds
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  // Result payload width, padded to whole bytes
  localparam int unsigned OUT_DATA_W = 24;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic parse;
    logic emit_start;
    logic load_char;
    logic next_field;
    logic load_close;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic start_emit;
    logic has_char;
    logic last_field;
    logic out_free;
  } stat_t;

endpackage : nrfe_pkg

`default_nettype wire

/* design/nmea_rmc_field_extractor.sv */
`default_nettype none

// NMEA 0183 RMC field extractor. Feed received serial bytes on the slave
// stream; a byte is taken whenever tvalid and tready are both high. A '$'
// opens a sentence, which is kept only if its fifth and sixth characters
// read "MC". Inside a kept sentence the time, latitude, N/S, longitude and
// E/W fields are captured (FIELD_CHARS characters each for the long fields,
// one for the hemisphere letters, excess dropped) and the first status
// character is checked for 'A'. On the newline the block drops tready and
// walks its field buffers: one character record per stored character, a
// step across each of the four field boundaries, and the closing record
// (tuser high, tlast high) carrying fix-valid and malformed (fewer than
// seven commas). The result register decouples the two sides, so the next
// byte is taken while the closing record waits.
module nmea_rmc_field_extractor #(
  parameter int unsigned FIELD_CHARS = nrfe_pkg::FIELD_CHARS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [7:0] rx_byte
  input  wire logic [7:0]                    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [2:0] field_id, [6:3] char_pos, [14:7] char_value, [15] fix_valid,
  // [16] malformed, [23:17] zero
  output logic [nrfe_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // [0] kind
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);
  import nrfe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  nrfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nrfe_datapath #(
    .FIELD_CHARS (FIELD_CHARS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_kind_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

`ifndef ASSERT_OFF
  // No byte is taken while the buffers are being walked
  a_no_accept_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_char || cmd.next_field) |-> !s_axis_tready_o)
    else $error("byte accepted during emission");

  // A closing request shows up as the last, closing record
  a_close_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_close |=> (m_axis_tvalid_o && m_axis_tlast_o && m_axis_tuser_o))
    else $error("closing record not presented");

  // Only the closing record ends the run
  a_last_is_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o)
    else $error("tlast on a character record");

  // A result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_char || cmd.load_close) |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result overwritten");
`endif

endmodule : nmea_rmc_field_extractor

`default_nettype wire

/* design/nrfe_ctrl.sv */
`default_nettype none

module nrfe_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire nrfe_pkg::stat_t stat_i,
  output nrfe_pkg::cmd_t      cmd_o
);
  import nrfe_pkg::*;

  state_e state_q, state_d;

  // Decide commands and next state
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.parse = 1'b1;
          if (stat_i.start_emit) begin
            cmd_o.emit_start = 1'b1;
            state_d          = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (stat_i.has_char) begin
          cmd_o.load_char = stat_i.out_free;
        end else if (stat_i.last_field) begin
          if (stat_i.out_free) begin
            cmd_o.load_close = 1'b1;
            state_d          = ST_IDLE;
          end
        end else begin
          cmd_o.next_field = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : nrfe_ctrl

`default_nettype wire

/* design/nrfe_datapath.sv */
`default_nettype none

module nrfe_datapath #(
  parameter int unsigned FIELD_CHARS = nrfe_pkg::FIELD_CHARS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [7:0]                        rx_byte_i,
  input  wire nrfe_pkg::cmd_t                    cmd_i,
  output nrfe_pkg::stat_t                        stat_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [nrfe_pkg::OUT_DATA_W-1:0]        out_data_o,
  output logic                                   out_kind_o,
  output logic                                   out_last_o
);
  import nrfe_pkg::*;

  localparam int unsigned LEN_W = $clog2(FIELD_CHARS + 1);
  localparam int unsigned IDX_W = $clog2(FIELD_CHARS);
  localparam logic [LEN_W-1:0] CAP = LEN_W'(FIELD_CHARS);

  // Sentence tracking
  logic [2:0]       pos_q;
  logic             header_ok_q;
  logic             in_sentence_q;
  logic [2:0]       comma_q;
  logic             status_active_q;
  logic             status_seen_q;
  logic [LEN_W-1:0] len_q [5];

  // Field buffers
  logic [7:0] time_q [FIELD_CHARS];
  logic [7:0] lat_q  [FIELD_CHARS];
  logic [7:0] lon_q  [FIELD_CHARS];
  logic [7:0] ns_q;
  logic [7:0] ew_q;

  // Emission walk
  logic [2:0]       fid_q;
  logic [LEN_W-1:0] idx_q;

  // Output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_kind_q;
  logic                  out_last_q;

  logic             is_dollar, is_lf, is_comma, in_body;
  logic             st_time, st_lat, st_ns, st_lon, st_ew;
  logic [LEN_W-1:0] cur_len;
  logic [7:0]       cur_char;

  assign is_dollar = (rx_byte_i == CHAR_DOLLAR);
  assign is_lf     = (rx_byte_i == CHAR_LF);
  assign is_comma  = (rx_byte_i == CHAR_COMMA);
  assign in_body   = cmd_i.parse && in_sentence_q && !is_dollar && !is_lf;

  // Store enables per field, capped by capacity
  assign st_time = in_body && !is_comma && (comma_q == 3'd1) && (len_q[0] < CAP);
  assign st_lat  = in_body && !is_comma && (comma_q == 3'd3) && (len_q[1] < CAP);
  assign st_ns   = in_body && !is_comma && (comma_q == 3'd4) && (len_q[2] == '0);
  assign st_lon  = in_body && !is_comma && (comma_q == 3'd5) && (len_q[3] < CAP);
  assign st_ew   = in_body && !is_comma && (comma_q == 3'd6) && (len_q[4] == '0);

  // Select the character under the walk
  always_comb begin
    cur_len  = len_q[0];
    cur_char = time_q[idx_q[IDX_W-1:0]];
    case (fid_q)
      FID_TIME: begin
        cur_len  = len_q[0];
        cur_char = time_q[idx_q[IDX_W-1:0]];
      end
      FID_LAT: begin
        cur_len  = len_q[1];
        cur_char = lat_q[idx_q[IDX_W-1:0]];
      end
      FID_NS: begin
        cur_len  = len_q[2];
        cur_char = ns_q;
      end
      FID_LON: begin
        cur_len  = len_q[3];
        cur_char = lon_q[idx_q[IDX_W-1:0]];
      end
      FID_EW: begin
        cur_len  = len_q[4];
        cur_char = ew_q;
      end
      default: begin
        cur_len  = '0;
        cur_char = '0;
      end
    endcase
  end

  assign stat_o.start_emit = in_sentence_q && header_ok_q && !is_dollar && is_lf;
  assign stat_o.has_char   = (idx_q < cur_len);
  assign stat_o.last_field = (fid_q == FID_EW);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Track the sentence: header, commas, field lengths and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q           <= '0;
      header_ok_q     <= 1'b0;
      in_sentence_q   <= 1'b0;
      comma_q         <= '0;
      status_active_q <= 1'b0;
      status_seen_q   <= 1'b0;
      for (int k = 0; k < 5; k++) begin
        len_q[k] <= '0;
      end
    end else if (cmd_i.parse) begin
      if (is_dollar) begin
        in_sentence_q   <= 1'b1;
        pos_q           <= 3'd1;
        header_ok_q     <= 1'b0;
        comma_q         <= '0;
        status_active_q <= 1'b0;
        status_seen_q   <= 1'b0;
        for (int k = 0; k < 5; k++) begin
          len_q[k] <= '0;
        end
      end else if (in_sentence_q) begin
        if (is_lf) begin
          in_sentence_q <= 1'b0;
        end else begin
          if (pos_q == 3'd4) begin
            header_ok_q <= (rx_byte_i == CHAR_M);
          end else if (pos_q == 3'd5) begin
            header_ok_q <= header_ok_q && (rx_byte_i == CHAR_C);
          end
          if (pos_q != 3'd7) begin
            pos_q <= pos_q + 3'd1;
          end
          if (is_comma) begin
            if (comma_q != 3'd7) begin
              comma_q <= comma_q + 3'd1;
            end
          end else if (comma_q == 3'd2 && !status_seen_q) begin
            status_seen_q   <= 1'b1;
            status_active_q <= (rx_byte_i == CHAR_A);
          end
          if (st_time) len_q[0] <= len_q[0] + 1'b1;
          if (st_lat)  len_q[1] <= len_q[1] + 1'b1;
          if (st_ns)   len_q[2] <= len_q[2] + 1'b1;
          if (st_lon)  len_q[3] <= len_q[3] + 1'b1;
          if (st_ew)   len_q[4] <= len_q[4] + 1'b1;
        end
      end
    end
  end

  // Write captured characters into the field buffers
  always_ff @(posedge clk_i) begin
    if (st_time) time_q[len_q[0][IDX_W-1:0]] <= rx_byte_i;
    if (st_lat)  lat_q[len_q[1][IDX_W-1:0]]  <= rx_byte_i;
    if (st_lon)  lon_q[len_q[3][IDX_W-1:0]]  <= rx_byte_i;
    if (st_ns)   ns_q <= rx_byte_i;
    if (st_ew)   ew_q <= rx_byte_i;
  end

  // Advance the emission walk over fields and positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fid_q <= FID_TIME;
      idx_q <= '0;
    end else if (cmd_i.emit_start) begin
      fid_q <= FID_TIME;
      idx_q <= '0;
    end else if (cmd_i.load_char) begin
      idx_q <= idx_q + 1'b1;
    end else if (cmd_i.next_field) begin
      fid_q <= fid_q + 3'd1;
      idx_q <= '0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_char || cmd_i.load_close) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      out_data_q <= {7'd0, 1'b0, 1'b0, cur_char, 4'(idx_q), fid_q};
      out_kind_q <= KIND_CHAR;
      out_last_q <= 1'b0;
    end else if (cmd_i.load_close) begin
      out_data_q <= {7'd0, (comma_q != 3'd7), status_active_q, 8'd0, 4'd0, 3'd0};
      out_kind_q <= KIND_CLOSE;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule : nrfe_datapath

`default_nettype wire
